// File: sv/pwrl_pkg.sv
`timescale 1ns / 1ps

package pwrl_pkg;

  // Field widths of the item and result
  localparam int LEN_W     = 16;
  localparam int TIME_W    = 64;
  localparam int COUNT_W   = 32;

  // Configuration register widths and the port layout
  localparam int RATE_W    = 29;
  localparam int OVH_W     = 16;
  localparam int WLEN_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 29;

  localparam logic [CFG_IDX_W-1:0] REG_BYTE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 2'd2;

  localparam logic [RATE_W-1:0] BYTE_RATE_RST = 29'd125000000;
  localparam logic [OVH_W-1:0]  OVERHEAD_RST  = 16'd0;
  localparam logic [WLEN_W-1:0] WIN_LEN_RST   = 7'd64;

  // Shared multiplier operand width
  localparam int MUL_W = 32;
  localparam logic [MUL_W-1:0] NS_PER_SEC = 32'd1000000000;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DELTA = 7'b0000100,
    S_MUL0  = 7'b0001000,
    S_MUL1  = 7'b0010000,
    S_MUL2  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

// File: sv/packet_window_rate_limiter.sv
`timescale 1ns / 1ps

// Sliding-window byte-rate policer. Each item carries a packet length and a
// 64-bit arrival time in ns; each item yields one result: a drop flag and the
// saturating drop count after this packet. The block keeps a ring of the last
// window_len accepted packets (arrival time and length less overhead). The
// packet is dropped when the window total including it, times 1e9, divided by
// the time since the oldest ring entry, exceeds byte_rate_limit; the test is
// done exactly as total*1e9 >= (limit+1)*elapsed. The block takes no new item
// until it has finished the last one and gone back to idle; it waits in its
// final step while the result register is still held by a stalled consumer.
// Each item takes one ring read, three passes through the single shared 32x32
// multiplier (total*1e9, then the low and high halves of (limit+1)*elapsed),
// and one wide compare. in_stall is high while an item is in work.
// The ring needs no clearing pass after reset: entries are always filled in
// order from slot 0, so a fill count tells which slots hold data. Write
// configuration only while the block is idle; cfg_ready is always high.
module packet_window_rate_limiter #(
  parameter int WINDOW = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pwrl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwrl_pkg::CFG_DAT_W-1:0]     cfg_data,
  // packet items in
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pwrl_pkg::LEN_W-1:0]         in_packet_len,
  input  logic [pwrl_pkg::TIME_W-1:0]        in_arrival_ns,
  // results out
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_drop,
  output logic [pwrl_pkg::COUNT_W-1:0]       out_drop_count
);

  import pwrl_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CMP_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int TOT_W = LEN_W + CNT_W;
  localparam int HALF_W = TIME_W / 2;
  localparam int WIDE_W = MUL_W + TIME_W;

  // Configuration registers
  logic [RATE_W-1:0] byte_rate_r;
  logic [OVH_W-1:0]  overhead_r;
  logic [WLEN_W-1:0] win_len_r;

  // Control state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   next_slot_r;
  logic [CNT_W-1:0]   fill_cnt_r;
  logic [TOT_W-1:0]   total_r;
  logic [COUNT_W-1:0] drops_r;
  logic               out_valid_r;
  logic               out_drop_r;

  // Item registers
  logic [LEN_W-1:0]   adj_r;
  logic [TIME_W-1:0]  now_r;
  logic [IDX_W-1:0]   idx_r;
  logic               filled_r;
  logic [TOT_W-1:0]   ntot_r;
  logic [TIME_W-1:0]  delta_r;
  logic [TIME_W-1:0]  lhs_r;
  logic [TIME_W-1:0]  rhs_lo_r;
  logic [TIME_W-1:0]  prod_r;

  // Ring memory
  logic [TIME_W-1:0]  time_mem [WINDOW];
  logic [LEN_W-1:0]   len_mem  [WINDOW];
  logic [TIME_W-1:0]  rd_time_r;
  logic [LEN_W-1:0]   rd_len_r;
  logic               mem_we;

  // Combinational helpers
  logic [CMP_W-1:0]   wl_cmp;
  logic [CNT_W-1:0]   wl;
  logic [IDX_W-1:0]   start_idx;
  logic [CNT_W-1:0]   idx_plus;
  logic [LEN_W-1:0]   adj_in;
  logic [LEN_W-1:0]   old_len;
  logic [TIME_W-1:0]  delta_raw;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [MUL_W-1:0]   lim1;
  logic [WIDE_W-1:0]  rhs_full;
  logic               drop_now;
  logic               in_acc;
  logic               out_free;

  assign cfg_ready      = 1'b1;
  assign in_stall       = (state_r != S_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_drop       = out_drop_r;
  assign out_drop_count = drops_r;
  assign out_free       = !out_valid_r || !out_stall;

  // Effective window length: zero acts as one, oversize clamps to WINDOW
  assign wl_cmp = CMP_W'(win_len_r);
  always_comb begin
    if (win_len_r == '0) begin
      wl = CNT_W'(1);
    end else if (wl_cmp > CMP_W'(WINDOW)) begin
      wl = CNT_W'(WINDOW);
    end else begin
      wl = CNT_W'(wl_cmp);
    end
  end

  // Fall back to slot 0 when the index lies beyond a shortened window
  assign start_idx = (CNT_W'(next_slot_r) < wl) ? next_slot_r : '0;
  assign idx_plus  = CNT_W'(idx_r) + CNT_W'(1);

  assign adj_in    = (in_packet_len > overhead_r) ? (in_packet_len - overhead_r) : in_packet_len;
  assign old_len   = filled_r ? rd_len_r : '0;
  assign delta_raw = now_r - rd_time_r;

  // (limit + 1) fits in 30 bits
  assign lim1 = MUL_W'(byte_rate_r) + MUL_W'(1);

  // Shared multiplier operand select
  always_comb begin
    case (state_r)
      S_MUL0: begin
        mul_a = MUL_W'(ntot_r);
        mul_b = NS_PER_SEC;
      end
      S_MUL1: begin
        mul_a = lim1;
        mul_b = delta_r[HALF_W-1:0];
      end
      S_MUL2: begin
        mul_a = lim1;
        mul_b = delta_r[TIME_W-1:HALF_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Assemble (limit+1)*elapsed from its two partial products and compare
  assign rhs_full = WIDE_W'(rhs_lo_r) + {prod_r, {HALF_W{1'b0}}};
  assign drop_now = filled_r && (WIDE_W'(lhs_r) >= rhs_full);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_READ;
      S_READ:  state_nxt = S_DELTA;
      S_DELTA: state_nxt = S_MUL0;
      S_MUL0:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          mem_we    = !drop_now;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_rate_r <= BYTE_RATE_RST;
      overhead_r  <= OVERHEAD_RST;
      win_len_r   <= WIN_LEN_RST;
      state_r     <= S_IDLE;
      next_slot_r <= '0;
      fill_cnt_r  <= '0;
      total_r     <= '0;
      drops_r     <= '0;
      out_valid_r <= 1'b0;
      out_drop_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BYTE_RATE: byte_rate_r <= cfg_data[RATE_W-1:0];
          REG_OVERHEAD:  overhead_r  <= cfg_data[OVH_W-1:0];
          REG_WIN_LEN:   win_len_r   <= cfg_data[WLEN_W-1:0];
          default: ;
        endcase
      end

      state_r <= state_nxt;

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        out_drop_r  <= drop_now;
        if (drop_now) begin
          // saturate at all ones
          if (drops_r != '1) begin
            drops_r <= drops_r + COUNT_W'(1);
          end
        end else begin
          total_r     <= ntot_r;
          next_slot_r <= (idx_plus >= wl) ? '0 : IDX_W'(idx_plus);
          if (idx_plus > fill_cnt_r) begin
            fill_cnt_r <= idx_plus;
          end
        end
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      adj_r <= adj_in;
      now_r <= in_arrival_ns;
      idx_r <= start_idx;
    end
    if (state_r == S_READ) begin
      filled_r <= (CNT_W'(idx_r) < fill_cnt_r);
    end
    if (state_r == S_DELTA) begin
      ntot_r  <= total_r + TOT_W'(adj_r) - TOT_W'(old_len);
      // zero elapsed time counts as 1 ns
      delta_r <= (delta_raw == '0) ? TIME_W'(1) : delta_raw;
    end
    if (state_r == S_MUL0 || state_r == S_MUL1 || state_r == S_MUL2) begin
      prod_r <= TIME_W'(mul_a) * TIME_W'(mul_b);
    end
    if (state_r == S_MUL1) begin
      lhs_r <= prod_r;
    end
    if (state_r == S_MUL2) begin
      rhs_lo_r <= prod_r;
    end
  end

  // Ring memory: one write port, registered read at the item's slot
  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[idx_r] <= now_r;
      len_mem[idx_r]  <= adj_r;
    end
    rd_time_r <= time_mem[idx_r];
    rd_len_r  <= len_mem[idx_r];
  end

  // An accepted item always starts with the ring read
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_READ))
    else $error("accepted item did not start the ring read");

  // A result appears only out of the final step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final step");

  // The fill count never runs past the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_cnt_r) <= CMP_W'(WINDOW) || CNT_W > CMP_W)
    else $error("fill count beyond ring depth");

  // The drop count moves only together with a dropped result
  a_drop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(drops_r)) |-> (out_valid_r && out_drop_r))
    else $error("drop count changed without a drop");

endmodule
